>>> rtl/core/vmma_pkg.sv
package vmma_pkg;

	// block configuration
	localparam int WINDOW    = 10;
	localparam int FRAC_BITS = 4;

	// field widths
	localparam int AXIS_W = 16;
	localparam int MEAN_W = 16;

	// sum of three squares of 16-bit signed values stays below 2^32
	localparam int SQ_W  = 2 * AXIS_W;
	localparam int RAD_W = SQ_W + 2 * FRAC_BITS;
	localparam int MAG_W = RAD_W / 2;
	localparam int REM_W = MAG_W + 2;
	localparam int CNT_W = $clog2(MAG_W);

	// window bookkeeping
	localparam int SUM_W  = MAG_W + $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int RMD_W  = $clog2(2 * WINDOW);

	// reciprocal of the window length, scaled by 2^SUM_W
	localparam longint RECIP = (64'd1 << SUM_W) / WINDOW;

	// queue between magnitude front end and window back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             restart;
	} vmma_item_t;

	typedef struct packed {
		logic       valid;
		vmma_item_t item;
	} vmma_xfer_t;

endpackage

>>> rtl/core/vmma_in_if.sv
interface vmma_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [vmma_pkg::AXIS_W-1:0]     accel_x;
	logic signed [vmma_pkg::AXIS_W-1:0]     accel_y;
	logic signed [vmma_pkg::AXIS_W-1:0]     accel_z;
	logic                                   restart;

	modport source(output valid, output accel_x, output accel_y, output accel_z,
		output restart, input ready);
	modport sink(input valid, input accel_x, input accel_y, input accel_z,
		input restart, output ready);
endinterface

>>> rtl/core/vmma_out_if.sv
interface vmma_out_if;
	logic                           valid;
	logic                           ready;
	logic [vmma_pkg::MEAN_W-1:0]    window_mean;

	modport source(output valid, output window_mean, input ready);
	modport sink(input valid, input window_mean, output ready);
endinterface

>>> rtl/core/vmma_front.sv
module vmma_front (
	input  logic                 clk,
	input  logic                 arst_n,
	vmma_in_if.sink              samples,
	output vmma_pkg::vmma_xfer_t push,
	input  logic                 full
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_LOAD = 4'b0010,
		F_ROOT = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	front_state_t state_q;

	logic [vmma_pkg::CNT_W-1:0]    cnt_q;
	logic [vmma_pkg::SQ_W-1:0]     sqx_q, sqy_q, sqz_q;
	logic                          restart_q;
	logic [vmma_pkg::RAD_W-1:0]    rad_q;
	logic [vmma_pkg::REM_W-1:0]    rem_q;
	logic [vmma_pkg::MAG_W-1:0]    root_q;

	logic signed [vmma_pkg::SQ_W-1:0] prod_x, prod_y, prod_z;
	logic [vmma_pkg::SQ_W-1:0]        sq_sum;
	logic [vmma_pkg::REM_W-1:0]       rem_shift, trial;
	logic                             take;

	assign samples.ready = (state_q == F_IDLE);

	assign prod_x = vmma_pkg::SQ_W'(samples.accel_x) * vmma_pkg::SQ_W'(samples.accel_x);
	assign prod_y = vmma_pkg::SQ_W'(samples.accel_y) * vmma_pkg::SQ_W'(samples.accel_y);
	assign prod_z = vmma_pkg::SQ_W'(samples.accel_z) * vmma_pkg::SQ_W'(samples.accel_z);
	assign sq_sum = sqx_q + sqy_q + sqz_q;

	// one root bit per cycle, two radicand bits shifted in
	assign rem_shift = {rem_q[vmma_pkg::REM_W-3:0], rad_q[vmma_pkg::RAD_W-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign take      = (rem_shift >= trial);

	assign push.valid        = (state_q == F_PUSH);
	assign push.item.mag     = root_q;
	assign push.item.restart = restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (samples.valid) state_q <= F_LOAD;
				end
				F_LOAD: begin
					cnt_q   <= '0;
					state_q <= F_ROOT;
				end
				F_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == vmma_pkg::CNT_W'(vmma_pkg::MAG_W - 1)) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && samples.valid) begin
			sqx_q     <= unsigned'(prod_x);
			sqy_q     <= unsigned'(prod_y);
			sqz_q     <= unsigned'(prod_z);
			restart_q <= samples.restart;
		end
		if (state_q == F_LOAD) begin
			rad_q  <= vmma_pkg::RAD_W'(sq_sum) << (2 * vmma_pkg::FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == F_ROOT) begin
			rad_q  <= rad_q << 2;
			rem_q  <= take ? (rem_shift - trial) : rem_shift;
			root_q <= {root_q[vmma_pkg::MAG_W-2:0], take};
		end
	end

endmodule

>>> rtl/core/vmma_queue.sv
module vmma_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vmma_pkg::vmma_xfer_t push,
	output logic                 full,
	output vmma_pkg::vmma_xfer_t head,
	input  logic                 pop
);

	vmma_pkg::vmma_item_t entries_q [vmma_pkg::QUEUE_DEPTH];

	logic [vmma_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [vmma_pkg::QCNT_W-1:0] count_q;
	logic                        do_push, do_pop;

	assign full       = (count_q == vmma_pkg::QCNT_W'(vmma_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == vmma_pkg::QPTR_W'(vmma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == vmma_pkg::QPTR_W'(vmma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_q] <= push.item;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vmma_pkg::QCNT_W'(vmma_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push.valid || !do_push)
		else $error("queue written while full");

endmodule

>>> rtl/core/vmma_back.sv
module vmma_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vmma_pkg::vmma_xfer_t head,
	output logic                 pop,
	vmma_out_if.source           means
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SUM  = 5'b00010,
		B_DIV  = 5'b00100,
		B_REM  = 5'b01000,
		B_OUT  = 5'b10000
	} back_state_t;

	back_state_t state_q;

	logic [vmma_pkg::MAG_W-1:0]    line_q [vmma_pkg::WINDOW];
	logic [vmma_pkg::MAG_W-1:0]    rd_q, mag_q;
	logic [vmma_pkg::SUM_W-1:0]    sum_q, quot_q;
	logic [vmma_pkg::FILL_W-1:0]   fill_q;
	logic [vmma_pkg::SLOT_W-1:0]   slot_q;
	logic [2*vmma_pkg::SUM_W-1:0]  prod_q;
	logic [vmma_pkg::RMD_W-1:0]    rmd_q;
	logic                          ovalid_q;
	logic [vmma_pkg::MEAN_W-1:0]   mean_q;

	logic                          full_win, out_load;
	logic [vmma_pkg::SLOT_W-1:0]   rd_slot;
	logic [vmma_pkg::SUM_W-1:0]    sum_next, quot_est, quot_w, quot_fix;

	assign pop      = (state_q == B_IDLE) && head.valid;
	assign rd_slot  = head.item.restart ? '0 : slot_q;
	assign full_win = (fill_q == vmma_pkg::FILL_W'(vmma_pkg::WINDOW));
	assign sum_next = sum_q - (full_win ? vmma_pkg::SUM_W'(rd_q) : '0)
		+ vmma_pkg::SUM_W'(mag_q);

	// reciprocal estimate is low by at most one
	assign quot_est = prod_q[2*vmma_pkg::SUM_W-1:vmma_pkg::SUM_W];
	assign quot_w   = quot_est * vmma_pkg::SUM_W'(vmma_pkg::WINDOW);
	assign quot_fix = quot_q
		+ vmma_pkg::SUM_W'(rmd_q >= vmma_pkg::RMD_W'(vmma_pkg::WINDOW));

	assign out_load = (state_q == B_OUT) && (!ovalid_q || means.ready);

	assign means.valid       = ovalid_q;
	assign means.window_mean = mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			fill_q   <= '0;
			slot_q   <= '0;
			sum_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (head.valid) begin
						if (head.item.restart) begin
							fill_q <= '0;
							slot_q <= '0;
							sum_q  <= '0;
						end
						state_q <= B_SUM;
					end
				end
				B_SUM: begin
					sum_q  <= sum_next;
					slot_q <= (slot_q == vmma_pkg::SLOT_W'(vmma_pkg::WINDOW - 1)) ? '0 : slot_q + 1'b1;
					if (!full_win) fill_q <= fill_q + 1'b1;
					if (full_win || fill_q == vmma_pkg::FILL_W'(vmma_pkg::WINDOW - 1)) begin
						state_q <= B_DIV;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_DIV: state_q <= B_REM;
				B_REM: state_q <= B_OUT;
				B_OUT: begin
					if (out_load) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			// output register: loaded with a new mean, or emptied when taken
			if (out_load) ovalid_q <= 1'b1;
			else if (means.ready) ovalid_q <= 1'b0;
		end
	end

	// magnitude delay line
	always_ff @(posedge clk) begin
		if (pop) rd_q <= line_q[rd_slot];
		if (state_q == B_SUM) line_q[slot_q] <= mag_q;
	end

	always_ff @(posedge clk) begin
		if (pop) mag_q <= head.item.mag;
		if (state_q == B_DIV) begin
			prod_q <= (2*vmma_pkg::SUM_W)'(sum_q) * (2*vmma_pkg::SUM_W)'(vmma_pkg::RECIP);
		end
		if (state_q == B_REM) begin
			quot_q <= quot_est;
			rmd_q  <= vmma_pkg::RMD_W'(sum_q - quot_w);
		end
		if (out_load) mean_q <= vmma_pkg::MEAN_W'(quot_fix >> vmma_pkg::FRAC_BITS);
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= vmma_pkg::FILL_W'(vmma_pkg::WINDOW))
		else $error("fill count beyond window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= vmma_pkg::SLOT_W'(vmma_pkg::WINDOW - 1))
		else $error("write slot beyond window");

	a_result_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> full_win)
		else $error("mean computed on a partial window");

endmodule

>>> rtl/core/vector_magnitude_moving_average_top.sv
// a sample passes the front end load, root and push states and the queue; the back end
//   sums it in and, once the window is full, divides, corrects and registers the mean
// the front end takes a new sample only after pushing the last magnitude, and its
//   bit-serial square root, one root bit per cycle, limits the sample rate
// reset: arst_n asynchronous active low, clears control state, window sum and fill count
module vector_magnitude_moving_average_top (
	input  logic        clk,
	input  logic        arst_n,
	vmma_in_if.sink     samples,
	vmma_out_if.source  means
);

	// front end: squares the three axes, sums them and takes the integer
	// square root of the sum scaled by 2^(2*FRAC_BITS); one item in flight
	vmma_pkg::vmma_xfer_t push;
	logic                 full;

	// queue output toward the window back end
	vmma_pkg::vmma_xfer_t head;
	logic                 pop;

	vmma_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.push    (push),
		.full    (full)
	);

	// short queue so the front end keeps working while the back end waits
	// on a stalled result transaction
	vmma_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	// back end: restart handling, delay line with running sum, and the
	// mean by reciprocal multiply with a one-step correction; the output
	// register holds a finished mean until the sink takes it
	vmma_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.means  (means)
	);

endmodule

>>> tb/tb_vector_magnitude_moving_average_top.sv
module tb_vector_magnitude_moving_average_top;

	localparam int AXIS_W    = vmma_pkg::AXIS_W;
	localparam int MAG_W     = vmma_pkg::MAG_W;
	localparam int MEAN_W    = vmma_pkg::MEAN_W;
	localparam int WINDOW    = vmma_pkg::WINDOW;
	localparam int FRAC_BITS = vmma_pkg::FRAC_BITS;

	// one sample transaction as the sender sees it
	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
		logic                     restart;
	} sample_t;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 10;
	// hard limit well above the length of the slowest legal run, with plenty of margin
	localparam int CYCLE_LIMIT  = 500000;
	// a few times the sample-to-mean latency of the front end plus back end
	localparam int DRAIN_CYCLES = 4 * (MAG_W + 7);

	logic clk = 1'b0;
	logic arst_n;

	vmma_in_if  samples_if();
	vmma_out_if means_if();

	vector_magnitude_moving_average_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.means  (means_if)
	);

	always #CLK_HALF clk = ~clk;

	// stimulus waiting to go out, and means still owed by the block
	sample_t             pending[$];
	logic [MEAN_W-1:0]   mean_q[$];

	// idling odds out of a hundred, changed only at the falling edge
	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int cycles;

	// own copy of the window: magnitudes, running sum, fill level, next slot
	longint unsigned mag_line[WINDOW];
	longint unsigned mag_sum;
	int              fill;
	int              slot;

	sample_t           on_bus;
	logic [MEAN_W-1:0] want;

	// ------------------------------------------------------------------
	// window predictor
	// ------------------------------------------------------------------

	task automatic clear_window();
		for (int i = 0; i < WINDOW; i++)
			mag_line[i] = 0;
		mag_sum = 0;
		fill    = 0;
		slot    = 0;
	endtask

	// append to the stimulus queue, or to the queue of owed means
	task automatic add_pending(input sample_t s);
		pending.insert(pending.size(), s);
	endtask

	task automatic owe_mean(input logic [MEAN_W-1:0] m);
		mean_q.insert(mean_q.size(), m);
	endtask

	// floor of the square root, built one bit at a time from the top
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	// euclidean magnitude with FRAC_BITS fractional bits, truncated
	function automatic longint unsigned magnitude(input sample_t s);
		longint signed   ax;
		longint signed   ay;
		longint signed   az;
		longint unsigned sq;
		ax = $signed(s.accel_x);
		ay = $signed(s.accel_y);
		az = $signed(s.accel_z);
		sq = ax * ax + ay * ay + az * az;
		return floor_root(sq << (2 * FRAC_BITS));
	endfunction

	// advance the window by one accepted sample, queue a mean once full
	task automatic take_sample(input sample_t s);
		longint unsigned mag;
		if (s.restart)
			clear_window();
		mag = magnitude(s);
		// full window: the oldest magnitude leaves the sum before it is overwritten
		if (fill >= WINDOW)
			mag_sum -= mag_line[slot];
		else
			fill++;
		mag_line[slot] = mag;
		mag_sum += mag;
		slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
		if (fill >= WINDOW)
			owe_mean(MEAN_W'((mag_sum / WINDOW) >> FRAC_BITS));
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic sample_t axes(input int x, input int y, input int z, input logic r);
		sample_t s;
		s.accel_x = AXIS_W'(x);
		s.accel_y = AXIS_W'(y);
		s.accel_z = AXIS_W'(z);
		s.restart = r;
		return s;
	endfunction

	// half full-range values, the rest extremes and tiny values
	function automatic logic [AXIS_W-1:0] pick_axis();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return AXIS_W'($urandom_range(15)) - AXIS_W'(8);
			default: return AXIS_W'($urandom());
		endcase
	endfunction

	function automatic sample_t make_sample(input logic r);
		sample_t s;
		s.accel_x = pick_axis();
		s.accel_y = pick_axis();
		s.accel_z = pick_axis();
		s.restart = r;
		return s;
	endfunction

	// windows opened by a restart: mostly long enough to produce means,
	// some cut short by the next restart, some with restart bits at random
	task automatic push_sequences(input int count);
		int made;
		int run_len;
		int kind;
		made = 0;
		while (made < count) begin
			kind = $urandom_range(9);
			if (kind < 7)
				run_len = $urandom_range(6 * WINDOW, WINDOW);
			else if (kind < 9)
				run_len = $urandom_range(WINDOW - 1, 1);
			else
				run_len = $urandom_range(8, 1);
			for (int k = 0; k < run_len; k++) begin
				if (kind == 9)
					add_pending(make_sample(1'($urandom_range(1))));
				else
					add_pending(make_sample(k == 0));
			end
			made += run_len;
		end
	endtask

	// one idling phase: set the odds, queue the batch, wait until all of it is on the bus
	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		push_sequences(count);
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// sample driver: holds a transaction until ready, then maybe idles
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready)
				take_sample(on_bus);
			// the bus is free when nothing is offered or the offer was just taken
			if (!samples_if.valid || samples_if.ready) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending.pop_front();
					samples_if.valid   <= 1'b1;
					samples_if.accel_x <= on_bus.accel_x;
					samples_if.accel_y <= on_bus.accel_y;
					samples_if.accel_z <= on_bus.accel_z;
					samples_if.restart <= on_bus.restart;
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// mean monitor: checks each accepted mean against the oldest one owed
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (means_if.valid && means_if.ready) begin
				if (mean_q.size() == 0) begin
					$error("window_mean: no transaction expected, actual %0d",
						means_if.window_mean);
					errors++;
				end else begin
					want = mean_q.pop_front();
					if (means_if.window_mean !== want) begin
						$error("window_mean: expected %0d, actual %0d",
							want, means_if.window_mean);
						errors++;
					end
				end
			end
			means_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// hard stop in case the block hangs or swallows a mean
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence: reset, directed samples, idling phases, drain
	// ------------------------------------------------------------------

	initial begin
		arst_n             = 1'b0;
		samples_if.valid   = 1'b0;
		samples_if.accel_x = '0;
		samples_if.accel_y = '0;
		samples_if.accel_z = '0;
		samples_if.restart = 1'b0;
		means_if.ready     = 1'b0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		errors             = 0;
		cycles             = 0;
		on_bus             = '0;
		clear_window();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// first window straight from reset, extremes of every axis
		add_pending(axes(-32768, -32768, -32768, 1'b0));
		add_pending(axes(32767, 32767, 32767, 1'b0));
		add_pending(axes(0, 0, 0, 1'b0));
		add_pending(axes(-32768, 0, 0, 1'b0));
		add_pending(axes(0, 32767, 0, 1'b0));
		add_pending(axes(0, 0, -1, 1'b0));
		add_pending(axes(1, 1, 1, 1'b0));
		add_pending(axes(-32768, 32767, -32768, 1'b0));
		add_pending(axes(32767, -32768, 32767, 1'b0));
		// tenth sample fills the window, the next one slides it
		add_pending(axes(-1, -1, -1, 1'b0));
		add_pending(axes(-32768, -32768, -32768, 1'b0));
		// restart on a full window, then cut short before it fills again
		add_pending(axes(12345, -23456, 7, 1'b1));
		add_pending(axes(-32768, -32768, -32768, 1'b0));
		add_pending(axes(32767, 0, -32768, 1'b0));
		// restart on a partial window, then exactly one window of max magnitude
		add_pending(axes(-32768, -32768, -32768, 1'b1));
		for (int i = 0; i < WINDOW - 1; i++)
			add_pending(axes(-32768, -32768, -32768, 1'b0));

		run_phase(0, 0, 250);
		run_phase(55, 0, 200);
		run_phase(0, 55, 200);
		run_phase(36, 36, 250);
		run_phase(0, 0, 150);

		// last transaction taken and every mean back, then let stragglers show
		while (samples_if.valid || mean_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> vector_magnitude_moving_average_top.f
rtl/core/vmma_pkg.sv
rtl/core/vmma_in_if.sv
rtl/core/vmma_out_if.sv
rtl/core/vmma_front.sv
rtl/core/vmma_queue.sv
rtl/core/vmma_back.sv
rtl/core/vector_magnitude_moving_average_top.sv
tb/tb_vector_magnitude_moving_average_top.sv
